FILE: rtl/olar_pkg.sv
package olar_pkg;

	// command codes carried on the input channel
	typedef enum logic {
		CMD_APPEND = 1'b0,
		CMD_REMOVE = 1'b1
	} cmd_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2
	} status_t;

	// operations of the shared arithmetic unit
	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

endpackage

FILE: rtl/olar_if.sv
interface olar_cmd_if #(
	parameter int VALUE_BITS = 31
);
	logic                  valid;
	logic                  ready;
	olar_pkg::cmd_t        command;
	logic [VALUE_BITS-1:0] value;

	modport source (output valid, output command, output value, input ready);
	modport sink   (input valid, input command, input value, output ready);
endinterface

interface olar_rsp_if #(
	parameter int COUNT_BITS = 9,
	parameter int SUM_BITS   = 39
);
	logic                  valid;
	logic                  ready;
	olar_pkg::status_t     status;
	logic [COUNT_BITS-1:0] entry_count;
	logic [SUM_BITS-1:0]   value_sum;

	modport source (output valid, output status, output entry_count, output value_sum,
		input ready);
	modport sink   (input valid, input status, input entry_count, input value_sum,
		output ready);
endinterface

FILE: rtl/olar_mem.sv
module olar_mem #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 31
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

FILE: rtl/olar_alu.sv
module olar_alu #(
	parameter int VALUE_BITS = 31,
	parameter int SUM_BITS   = 39
) (
	input  olar_pkg::alu_op_t     op,
	input  logic [SUM_BITS-1:0]   acc,
	input  logic [VALUE_BITS-1:0] opnd,
	input  logic [VALUE_BITS-1:0] key,
	output logic [SUM_BITS-1:0]   result,
	output logic                  match
);
	logic [SUM_BITS-1:0] opnd_ext;

	assign opnd_ext = {{(SUM_BITS-VALUE_BITS){1'b0}}, opnd};
	assign match    = (opnd == key);

	always_comb begin
		case (op)
			olar_pkg::ALU_ADD: result = acc + opnd_ext;
			olar_pkg::ALU_SUB: result = acc - opnd_ext;
			default:           result = acc;
		endcase
	end
endmodule

FILE: rtl/ordered_list_append_remove.sv
// channel | dir | beat payload                        | accepted when
// cmd     | in  | command, value                      | cmd.valid && cmd.ready
// rsp     | out | status, entry_count, value_sum      | rsp.valid && rsp.ready
//
// append goes from accept to write and add, then to finish; a full list goes straight to finish
// remove reads one entry per cycle until a match, then moves each later entry up one slot;
// a miss ends once the last entry is compared, and an empty list goes straight to finish
// reset clears state, count, sum and the valid flags, not the entries; entries are written before they are read
// a result waits in the output register while the next command is accepted;
// that command finishes once the output register is free
module ordered_list_append_remove #(
	parameter int CAPACITY   = 256,
	parameter int VALUE_BITS = 31
) (
	input  logic               clk,
	input  logic               arst_n,
	olar_cmd_if.sink           cmd,
	olar_rsp_if.source         rsp
);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1; // memory address bits
	localparam int CW = $clog2(CAPACITY + 1);                  // count bits
	localparam int SW = VALUE_BITS + AW;                       // sum bits, never overflows

	// one-hot sequencer states
	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_APPEND = 5'b00010,
		S_SEARCH = 5'b00100,
		S_SHIFT  = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	state_t                state_q, state_d;
	logic [VALUE_BITS-1:0] val_q, val_d;
	logic [CW-1:0]         count_q, count_d;
	logic [SW-1:0]         sum_q, sum_d;
	olar_pkg::status_t     status_q, status_d;

	// read stream: next address to read, and the address whose data is back
	logic [CW-1:0]         rd_ptr_q, rd_ptr_d;
	logic                  rd_vld_s1, rd_vld_d;
	logic [CW-1:0]         rd_pos_s1, rd_pos_d;

	// output register
	logic                  out_valid_q;
	olar_pkg::status_t     out_status_q;
	logic [CW-1:0]         out_count_q;
	logic [SW-1:0]         out_sum_q;
	logic                  out_free;
	logic                  out_load;

	// memory and shared unit hookup
	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [VALUE_BITS-1:0] mem_wdata;
	logic                  mem_re;
	logic [VALUE_BITS-1:0] mem_rdata;
	olar_pkg::alu_op_t     alu_op;
	logic [VALUE_BITS-1:0] alu_opnd;
	logic [SW-1:0]         alu_result;
	logic                  alu_match;

	logic                  cmd_fire;
	logic                  rd_more;
	logic [CW-1:0]         wr_pos;

	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign rd_more   = (rd_ptr_q < count_q);
	assign wr_pos    = rd_pos_s1 - CW'(1);

	olar_mem #(
		.DEPTH (CAPACITY),
		.WIDTH (VALUE_BITS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (rd_ptr_q[AW-1:0]),
		.rdata (mem_rdata)
	);

	// add on append, subtract the removed entry, compare while searching
	olar_alu #(
		.VALUE_BITS (VALUE_BITS),
		.SUM_BITS   (SW)
	) u_alu (
		.op     (alu_op),
		.acc    (sum_q),
		.opnd   (alu_opnd),
		.key    (val_q),
		.result (alu_result),
		.match  (alu_match)
	);

	always_comb begin
		state_d   = state_q;
		val_d     = val_q;
		count_d   = count_q;
		sum_d     = sum_q;
		status_d  = status_q;
		rd_ptr_d  = rd_ptr_q;
		rd_vld_d  = 1'b0;
		rd_pos_d  = rd_pos_s1;
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_wdata = val_q;
		mem_re    = 1'b0;
		alu_op    = olar_pkg::ALU_SUB;
		alu_opnd  = mem_rdata;
		out_load  = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (cmd_fire) begin
					val_d    = cmd.value;
					rd_ptr_d = '0;
					if (cmd.command == olar_pkg::CMD_APPEND) begin
						if (count_q == CW'(CAPACITY)) begin
							status_d = olar_pkg::ST_FULL;
							state_d  = S_FINISH;
						end else begin
							state_d = S_APPEND;
						end
					end else if (count_q == '0) begin
						status_d = olar_pkg::ST_MISSING;
						state_d  = S_FINISH;
					end else begin
						state_d = S_SEARCH;
					end
				end
			end
			S_APPEND: begin
				mem_we   = 1'b1;
				alu_op   = olar_pkg::ALU_ADD;
				alu_opnd = val_q;
				sum_d    = alu_result;
				count_d  = count_q + CW'(1);
				status_d = olar_pkg::ST_DONE;
				state_d  = S_FINISH;
			end
			S_SEARCH: begin
				// keep one read in flight, compare the entry that came back
				mem_re   = rd_more;
				rd_vld_d = rd_more;
				rd_pos_d = rd_ptr_q;
				if (rd_more) begin
					rd_ptr_d = rd_ptr_q + CW'(1);
				end
				if (rd_vld_s1 && alu_match) begin
					sum_d    = alu_result;
					rd_ptr_d = rd_pos_s1 + CW'(1);
					rd_vld_d = 1'b0;
					state_d  = S_SHIFT;
				end else if (rd_vld_s1 && (rd_pos_s1 == count_q - CW'(1))) begin
					status_d = olar_pkg::ST_MISSING;
					state_d  = S_FINISH;
				end
			end
			S_SHIFT: begin
				// read entry i, write it back to slot i-1 in the cycle after
				mem_re    = rd_more;
				rd_vld_d  = rd_more;
				rd_pos_d  = rd_ptr_q;
				mem_we    = rd_vld_s1;
				mem_waddr = wr_pos[AW-1:0];
				mem_wdata = mem_rdata;
				if (rd_more) begin
					rd_ptr_d = rd_ptr_q + CW'(1);
				end
				if (!rd_vld_s1 && !rd_more) begin
					count_d  = count_q - CW'(1);
					status_d = olar_pkg::ST_DONE;
					state_d  = S_FINISH;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			sum_q       <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			sum_q     <= sum_d;
			rd_vld_s1 <= rd_vld_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		val_q     <= val_d;
		status_q  <= status_d;
		rd_ptr_q  <= rd_ptr_d;
		rd_pos_s1 <= rd_pos_d;
		if (out_load) begin
			out_status_q <= status_q;
			out_count_q  <= count_q;
			out_sum_q    <= sum_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.entry_count = out_count_q;
	assign rsp.value_sum   = out_sum_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status == olar_pkg::ST_FULL)) |-> (rsp.entry_count == CW'(CAPACITY)))
		else $error("full reported below capacity");

	a_search_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH) |-> (count_q != '0))
		else $error("search on an empty list");

	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SHIFT) && (state_d == S_FINISH)) |=> (count_q == $past(count_q) - CW'(1)))
		else $error("remove did not drop the count by one");
`endif
endmodule

FILE: dv/ordered_list_append_remove_checker.sv
module ordered_list_append_remove_checker #(
	parameter int CAPACITY   = 256,
	parameter int VALUE_BITS = 31
) (
	input  logic clk,
	input  logic arst_n,
	olar_cmd_if  cmd,
	olar_rsp_if  rsp,
	output int   mismatches,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		olar_pkg::status_t status;
		logic [8:0]        entry_count;
		logic [38:0]       value_sum;
	} list_result_t;

	// mirror of the list contents, head first
	logic [VALUE_BITS-1:0] held_values[$];
	logic [38:0]           held_sum;
	list_result_t          due_results[$];

	function automatic list_result_t apply_command(olar_pkg::cmd_t op,
		logic [VALUE_BITS-1:0] v);
		list_result_t r;
		int           hit;
		r.status = olar_pkg::ST_DONE;
		hit      = -1;
		if (op == olar_pkg::CMD_APPEND) begin
			if (held_values.size() >= CAPACITY) begin
				r.status = olar_pkg::ST_FULL;
			end else begin
				held_values.push_back(v);
				held_sum = held_sum + 39'(v);
			end
		end else begin
			// first match from the head only
			for (int i = 0; i < held_values.size(); i++)
				if (hit < 0 && held_values[i] == v)
					hit = i;
			if (hit < 0) begin
				r.status = olar_pkg::ST_MISSING;
			end else begin
				held_values.delete(hit);
				held_sum = held_sum - 39'(v);
			end
		end
		r.entry_count = 9'(held_values.size());
		r.value_sum   = held_sum;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_result_t seen;
		list_result_t want;
		if (!arst_n) begin
			held_values.delete();
			due_results.delete();
			held_sum    = '0;
			mismatches  = 0;
			outstanding <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				seen.status      = rsp.status;
				seen.entry_count = rsp.entry_count;
				seen.value_sum   = rsp.value_sum;
				if (due_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result with none due: status %0d count %0d sum %0d",
							seen.status, seen.entry_count, seen.value_sum);
				end else begin
					want = due_results.pop_front();
					if (seen.status !== want.status || seen.entry_count !== want.entry_count
						|| seen.value_sum !== want.value_sum) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: status %0d/%0d count %0d/%0d sum %0d/%0d (exp/act)",
								want.status, seen.status, want.entry_count, seen.entry_count,
								want.value_sum, seen.value_sum);
					end
				end
			end
			if (cmd.valid && cmd.ready)
				due_results.push_back(apply_command(cmd.command, cmd.value));
			outstanding <= due_results.size();
		end
	end

endmodule

FILE: dv/ordered_list_append_remove_tb.sv
module ordered_list_append_remove_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY      = 256;
	localparam int VALUE_BITS    = 31;
	localparam int RANDOM_ITEMS  = 1900;
	localparam int IDLE_PCT      = 31;
	// worst remove walks and shifts the whole list, so settle well past that
	localparam int SETTLE_CYCLES = CAPACITY + 40;
	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

	logic clk;
	logic arst_n;
	logic quiet;   // no idling on either side while set
	int   cycles = 0;
	int   mismatches;
	int   outstanding;

	// small set of values reused so removes find something
	logic [VALUE_BITS-1:0] value_pool[16];
	// rough copy of what the list holds, only to aim removes at live entries
	logic [VALUE_BITS-1:0] live_values[$];

	olar_cmd_if #(.VALUE_BITS(VALUE_BITS)) cmd_ch();
	olar_rsp_if #(.COUNT_BITS(9), .SUM_BITS(39)) rsp_ch();

	ordered_list_append_remove #(
		.CAPACITY  (CAPACITY),
		.VALUE_BITS(VALUE_BITS)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.rsp   (rsp_ch)
	);

	ordered_list_append_remove_checker #(
		.CAPACITY  (CAPACITY),
		.VALUE_BITS(VALUE_BITS)
	) list_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_ch),
		.rsp        (rsp_ch),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// result side back-pressure
	always @(posedge clk) begin
		rsp_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
	end

	// one command beat: random gap first, then hold until taken
	task automatic send_beat(input olar_pkg::cmd_t op, input logic [VALUE_BITS-1:0] v);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.command <= op;
		cmd_ch.value   <= v;
		// ready is stable mid-cycle, so look there and then step to the accepting edge
		do @(negedge clk); while (!cmd_ch.ready);
		@(posedge clk);
	endtask

	// mostly pool values, some full-width noise, some extremes
	function automatic logic [VALUE_BITS-1:0] pick_value();
		int roll = $urandom_range(99);
		if (roll < 70)
			return value_pool[$urandom_range(15)];
		if (roll < 90)
			return VALUE_BITS'($urandom());
		return ($urandom_range(1) != 0) ? VALUE_MAX : '0;
	endfunction

	initial begin
		int                    sent;
		int                    phase_len;
		int                    append_pct;
		int                    slot;
		logic [VALUE_BITS-1:0] v;

		arst_n         <= 1'b0;
		quiet          <= 1'b0;
		cmd_ch.valid   <= 1'b0;
		cmd_ch.command <= olar_pkg::CMD_APPEND;
		cmd_ch.value   <= '0;

		value_pool[0] = '0;
		value_pool[1] = VALUE_MAX;
		for (int i = 2; i < 16; i++)
			value_pool[i] = (i < 8) ? VALUE_BITS'($urandom_range(15)) : VALUE_BITS'($urandom());

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// remove from an empty list
		send_beat(olar_pkg::CMD_REMOVE, VALUE_BITS'(5));
		// extremes of the value field and alternating bit patterns
		send_beat(olar_pkg::CMD_APPEND, '0);
		send_beat(olar_pkg::CMD_APPEND, VALUE_MAX);
		send_beat(olar_pkg::CMD_APPEND, VALUE_BITS'(5));
		send_beat(olar_pkg::CMD_APPEND, VALUE_BITS'(5));
		send_beat(olar_pkg::CMD_APPEND, 31'h2AAA_AAAA);
		send_beat(olar_pkg::CMD_APPEND, 31'h5555_5555);
		// duplicates go one at a time, head side first, then none left
		send_beat(olar_pkg::CMD_REMOVE, VALUE_BITS'(5));
		send_beat(olar_pkg::CMD_REMOVE, VALUE_BITS'(5));
		send_beat(olar_pkg::CMD_REMOVE, VALUE_BITS'(5));
		// middle, head and tail removal
		send_beat(olar_pkg::CMD_REMOVE, VALUE_MAX);
		send_beat(olar_pkg::CMD_REMOVE, '0);
		send_beat(olar_pkg::CMD_REMOVE, 31'h5555_5555);
		// no match in a non-empty list, then remove the last entry
		send_beat(olar_pkg::CMD_REMOVE, VALUE_BITS'(1));
		send_beat(olar_pkg::CMD_REMOVE, 31'h2AAA_AAAA);

		// phases: fill past capacity, quiet mixed traffic, drain to empty, then random mixes
		sent = 0;
		for (int phase = 0; sent < RANDOM_ITEMS; phase++) begin
			case (phase)
				0: begin
					append_pct = 95;
					phase_len  = 300;
				end
				1: begin
					append_pct = 50;
					phase_len  = 250;
				end
				2: begin
					append_pct = 5;
					phase_len  = 300;
				end
				default: begin
					append_pct = ($urandom_range(2) == 0) ? 90 : (($urandom_range(1) != 0) ? 50 : 10);
					phase_len  = $urandom_range(60, 250);
				end
			endcase
			quiet <= (phase == 1);
			for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
				if ($urandom_range(99) < append_pct) begin
					v = pick_value();
					if (live_values.size() < CAPACITY)
						live_values.push_back(v);
					send_beat(olar_pkg::CMD_APPEND, v);
				end else if (live_values.size() != 0 && $urandom_range(3) != 0) begin
					// aim at an entry that should be there
					slot = $urandom_range(live_values.size() - 1);
					v    = live_values[slot];
					live_values.delete(slot);
					send_beat(olar_pkg::CMD_REMOVE, v);
				end else begin
					send_beat(olar_pkg::CMD_REMOVE, pick_value());
				end
				sent++;
			end
		end
		cmd_ch.valid <= 1'b0;

		// let every result come back, then a little longer for strays
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: sim.f
rtl/olar_pkg.sv
rtl/olar_if.sv
rtl/olar_mem.sv
rtl/olar_alu.sv
rtl/ordered_list_append_remove.sv
dv/ordered_list_append_remove_checker.sv
dv/ordered_list_append_remove_tb.sv
